// ===== sv/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge while out of reset.
`define ASSERT_CLK(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// Check an implication on every rising clock edge while out of reset.
`define ASSERT_IMPL(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("implication failed");

`endif

// ===== sv/srrb_pkg.sv =====
// ---------------------------------------------------------------------------
// Replay buffer package
// Item types, operation codes and sequencer states of the replay buffer.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package srrb_pkg;

  typedef enum logic [2:0] {
    FN_ADD    = 3'd0,
    FN_ACK    = 3'd1,
    FN_FREE   = 3'd2,
    FN_SETRTX = 3'd3,
    FN_RESENT = 3'd4,
    FN_LOOKUP = 3'd5
  } func_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_FREE
  } state_e;

  typedef struct packed {
    logic [2:0]  func;
    logic [15:0] seq_num;
    logic [15:0] range_end;
    logic [31:0] packet_handle;
    logic        flag_value;
    logic [62:0] now_time;
  } req_t;

  typedef struct packed {
    logic        tag_hit;
    logic        overwrite_warning;
    logic        is_acked;
    logic        is_resending;
    logic [7:0]  resend_count;
    logic [62:0] sent_time;
    logic [31:0] handle_out;
    logic [8:0]  slots_freed;
  } rsp_t;

  typedef struct packed {
    logic [15:0] tag;
    logic        acked;
    logic        resending;
    logic [7:0]  count;
    logic [62:0] sent_time;
    logic [31:0] handle;
  } slot_t;

endpackage

`default_nettype wire

// ===== sv/selective_repeat_replay_buffer.sv =====
// ---------------------------------------------------------------------------
// Selective-repeat replay buffer
// Sequence-number indexed retransmit table with add, ack, flag, resend,
// lookup and range free operations.
// ---------------------------------------------------------------------------
// Usage: one request item enters on the in channel (valid/ready) and gives
// exactly one response item on the out channel (valid/ready). Sequence
// number sn lives in slot sn mod DEPTH; DEPTH and SEQ_SPACE are powers of two.
// Single-slot operations: the accepting edge starts the slot memory read;
// in ST_EXEC, once the output register is free, the slot is compared and
// written back through the shared update logic and the response is registered.
// A range free walks one slot per cycle and clears N slots (N <= DEPTH),
// then registers its response with the count once the output register is free.
// The block takes one item at a time; in_ready_o is high while the
// sequencer is idle, including while a response waits in the output
// register. If the receiver stalls, the response is held and a finished
// operation waits before write-back until the output register frees up.
// Reset clears all slot valid bits at once, so every slot reads as empty
// straight away; slot contents are only ever seen through a valid slot.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module selective_repeat_replay_buffer #(
  parameter int DEPTH     = 256,
  parameter int SEQ_SPACE = 65536
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire srrb_pkg::req_t in_data_i,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output srrb_pkg::rsp_t     out_data_o
);
  import srrb_pkg::*;

  localparam int IDX_W = $clog2(DEPTH);
  localparam int SEQ_W = $clog2(SEQ_SPACE);
  localparam int CNT_W = $clog2(DEPTH + 1);

  state_e             state_q, state_d;
  req_t               req_q, req_d;
  slot_t              mem [DEPTH];
  slot_t              entry_q;
  logic               rd_en;
  logic [IDX_W-1:0]   rd_idx;
  logic               wr_en;
  slot_t              wr_data;
  logic [DEPTH-1:0]   valid_q, valid_d;
  logic [SEQ_W-1:0]   cur_q, cur_d, stop_q, stop_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic               out_valid_q, out_valid_d;
  rsp_t               out_q, out_d;
  logic               out_free;
  logic               hit;
  logic [IDX_W-1:0]   slot_idx;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign out_free    = !out_valid_q || out_ready_i;
  assign slot_idx    = IDX_W'(req_q.seq_num);
  assign rd_idx      = IDX_W'(in_data_i.seq_num);
  assign hit         = valid_q[slot_idx] && (entry_q.tag == req_q.seq_num);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      valid_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      valid_q     <= valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q  <= req_d;
    cur_q  <= cur_d;
    stop_q <= stop_d;
    cnt_q  <= cnt_d;
    out_q  <= out_d;
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      entry_q <= mem[rd_idx];
    end
    if (wr_en) begin
      mem[slot_idx] <= wr_data;
    end
  end

  always_comb begin
    state_d     = state_q;
    req_d       = req_q;
    cur_d       = cur_q;
    stop_d      = stop_q;
    cnt_d       = cnt_q;
    valid_d     = valid_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    rd_en       = 1'b0;
    wr_en       = 1'b0;
    wr_data     = entry_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          req_d  = in_data_i;
          cur_d  = SEQ_W'(in_data_i.seq_num);
          stop_d = SEQ_W'(in_data_i.range_end);
          cnt_d  = '0;
          rd_en  = 1'b1;
          state_d = (in_data_i.func == FN_FREE) ? ST_FREE : ST_EXEC;
        end
      end

      ST_EXEC: begin
        if (out_free) begin
          out_d       = '0;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
          case (req_q.func)
            FN_ADD: begin
              out_d.tag_hit           = hit;
              out_d.overwrite_warning = valid_q[slot_idx] && !entry_q.acked;
              wr_en                   = 1'b1;
              wr_data.tag             = req_q.seq_num;
              wr_data.acked           = 1'b0;
              wr_data.resending       = 1'b0;
              wr_data.count           = '0;
              wr_data.sent_time       = req_q.now_time;
              wr_data.handle          = req_q.packet_handle;
              valid_d[slot_idx]       = 1'b1;
            end
            FN_ACK: begin
              out_d.tag_hit = hit;
              wr_en         = hit;
              wr_data.acked = 1'b1;
            end
            FN_SETRTX: begin
              out_d.tag_hit     = hit;
              wr_en             = hit;
              wr_data.resending = req_q.flag_value;
            end
            FN_RESENT: begin
              out_d.tag_hit     = hit;
              wr_en             = hit;
              wr_data.sent_time = req_q.now_time;
              wr_data.count     = entry_q.count + 8'd1;
            end
            FN_LOOKUP: begin
              out_d.tag_hit = hit;
              if (hit) begin
                out_d.is_acked     = entry_q.acked;
                out_d.is_resending = entry_q.resending;
                out_d.resend_count = entry_q.count;
                out_d.sent_time    = entry_q.sent_time;
                out_d.handle_out   = entry_q.handle;
              end else begin
                out_d.is_acked = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end

      ST_FREE: begin
        // Walk one slot a cycle; stop at the end or once every slot is cleared.
        if ((cur_q == stop_q) || (cnt_q == CNT_W'(DEPTH))) begin
          if (out_free) begin
            out_d             = '0;
            out_d.slots_freed = 9'(cnt_q);
            out_valid_d       = 1'b1;
            state_d           = ST_IDLE;
          end
        end else begin
          valid_d[IDX_W'(cur_q)] = 1'b0;
          cur_d = cur_q + SEQ_W'(1);
          cnt_d = cnt_q + CNT_W'(1);
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

endmodule

`default_nettype wire

// ===== sv/srrb_checker.sv =====
// ---------------------------------------------------------------------------
// Replay buffer checker
// Port-level properties of the replay buffer responses.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module srrb_checker (
  input wire logic           clk_i,
  input wire logic           rst_ni,
  input wire logic           in_valid_i,
  input wire logic           in_ready_o,
  input wire logic           out_valid_o,
  input wire logic           out_ready_i,
  input wire srrb_pkg::rsp_t out_data_o
);
  import srrb_pkg::*;

  // Hold a stalled response.
  `ASSERT_CLK(a_out_hold, clk_i, rst_ni, (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(out_data_o)))

  // A free response carries nothing from the per-slot operations.
  `ASSERT_IMPL(a_free_clean, clk_i, rst_ni, out_valid_o && (out_data_o.slots_freed != 9'd0), !out_data_o.tag_hit && !out_data_o.overwrite_warning && !out_data_o.is_acked)

  // A miss never reports slot contents.
  `ASSERT_IMPL(a_miss_empty, clk_i, rst_ni, out_valid_o && !out_data_o.tag_hit, (out_data_o.resend_count == 8'd0) && (out_data_o.handle_out == 32'd0) && !out_data_o.is_resending)

  // An overwrite warning comes only from an add, never with lookup fields.
  `ASSERT_IMPL(a_warn_add, clk_i, rst_ni, out_valid_o && out_data_o.overwrite_warning, !out_data_o.is_acked && (out_data_o.sent_time == 63'd0))

  // One item at a time: no acceptance in the cycle after an acceptance.
  `ASSERT_CLK(a_one_item, clk_i, rst_ni, (in_valid_i && in_ready_o) |=> !in_ready_o)

endmodule

bind selective_repeat_replay_buffer srrb_checker u_srrb_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_ready_o (in_ready_o),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .out_data_o (out_data_o)
);

`default_nettype wire

// ===== test/tb_selective_repeat_replay_buffer.sv =====
// ---------------------------------------------------------------------------
// Replay buffer testbench
// Drives request items into the replay buffer and checks every response
// against a slot-table predictor kept in the bench, with random stalls on
// both channels.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_selective_repeat_replay_buffer;
  import srrb_pkg::*;

  localparam int DEPTH     = 256;
  localparam int SEQ_SPACE = 65536;
  localparam int WATCHDOG  = 20000;
  localparam logic [2:0] FN_BAD6 = 3'd6;
  localparam logic [2:0] FN_BAD7 = 3'd7;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  req_t in_data_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  rsp_t out_data_o;

  always #4 clk_i = ~clk_i;

  selective_repeat_replay_buffer #(.DEPTH(DEPTH), .SEQ_SPACE(SEQ_SPACE)) u_top (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_data_i,
    .out_valid_o, .out_ready_i, .out_data_o
  );

  // predicted slot table
  logic        tbl_valid [DEPTH];
  logic [15:0] tbl_tag   [DEPTH];
  logic        tbl_acked [DEPTH];
  logic        tbl_rtx   [DEPTH];
  logic [7:0]  tbl_count [DEPTH];
  logic [62:0] tbl_time  [DEPTH];
  logic [31:0] tbl_handle[DEPTH];

  rsp_t expected_rsp[$];
  int   errors = 0;
  int   idle_pct = 22;
  bit   rx_hold = 1'b0;
  int   quiet_cycles = 0;
  logic [15:0] next_sn = 16'd0;

  function automatic void clear_slot(int i);
    tbl_valid[i] = 1'b0; tbl_tag[i] = 16'hFFFF; tbl_acked[i] = 1'b1;
    tbl_rtx[i] = 1'b0; tbl_count[i] = '0; tbl_time[i] = '0; tbl_handle[i] = '0;
  endfunction

  function automatic rsp_t predict_table(req_t r);
    rsp_t  o;
    int    i;
    logic  hit;
    bit    seen[DEPTH];
    int    cur, freed;
    o = '0;
    i = r.seq_num % DEPTH;
    hit = tbl_valid[i] && tbl_tag[i] == r.seq_num;
    case (r.func)
      FN_ADD: begin
        o.tag_hit = hit;
        o.overwrite_warning = !tbl_acked[i];
        tbl_valid[i] = 1'b1; tbl_tag[i] = r.seq_num; tbl_acked[i] = 1'b0;
        tbl_rtx[i] = 1'b0; tbl_count[i] = '0; tbl_time[i] = r.now_time;
        tbl_handle[i] = r.packet_handle;
      end
      FN_ACK: begin
        o.tag_hit = hit;
        if (hit) tbl_acked[i] = 1'b1;
      end
      FN_FREE: begin
        cur = r.seq_num;
        freed = 0;
        while (cur != r.range_end && freed < DEPTH) begin
          if (!seen[cur % DEPTH]) begin
            seen[cur % DEPTH] = 1'b1;
            freed++;
          end
          clear_slot(cur % DEPTH);
          cur = (cur + 1) % SEQ_SPACE;
        end
        o.slots_freed = freed[8:0];
      end
      FN_SETRTX: begin
        o.tag_hit = hit;
        if (hit) tbl_rtx[i] = r.flag_value;
      end
      FN_RESENT: begin
        o.tag_hit = hit;
        if (hit) begin
          tbl_time[i] = r.now_time;
          tbl_count[i] = tbl_count[i] + 8'd1;
        end
      end
      FN_LOOKUP: begin
        o.tag_hit = hit;
        if (hit) begin
          o.is_acked = tbl_acked[i]; o.is_resending = tbl_rtx[i];
          o.resend_count = tbl_count[i]; o.sent_time = tbl_time[i];
          o.handle_out = tbl_handle[i];
        end else begin
          o.is_acked = 1'b1;
        end
      end
      default: ;
    endcase
    return o;
  endfunction

  // send one item; the prediction is made at the accepting edge
  task automatic send_item(req_t r);
    @(negedge clk_i);
    while (($urandom % 100) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= r;
    do @(posedge clk_i); while (!in_ready_o);
    expected_rsp.push_back(predict_table(r));
  endtask

  // drop valid after the last item of a sequence
  task automatic stop_sending();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
  endtask

  function automatic req_t rand_req(logic [2:0] fn, logic [15:0] sn);
    req_t r;
    r.func = fn;
    r.seq_num = sn;
    r.range_end = 16'(sn + $urandom_range(0, 300));
    r.packet_handle = $urandom;
    r.flag_value = 1'($urandom_range(0, 1));
    r.now_time = 63'({$urandom, $urandom});
    return r;
  endfunction

  task automatic drain_results();
    while (expected_rsp.size() != 0) @(negedge clk_i);
    repeat (DEPTH + 8) @(negedge clk_i);
  endtask

  // receiver side
  always @(negedge clk_i) begin
    if (rx_hold) out_ready_i <= 1'b0;
    else out_ready_i <= (($urandom % 100) >= idle_pct);
  end

  always @(posedge clk_i) begin
    rsp_t exp_r;
    if (out_valid_o && out_ready_i) begin
      if (expected_rsp.size() == 0) begin
        $display("%0t: unexpected result %h", $time, out_data_o);
        errors++;
      end else begin
        exp_r = expected_rsp.pop_front();
        if (out_data_o !== exp_r) begin
          $display("%0t: mismatch expected %h actual %h", $time, exp_r, out_data_o);
          if (out_data_o.tag_hit !== exp_r.tag_hit)
            $display("%0t:  tag_hit exp %b act %b", $time, exp_r.tag_hit,
                     out_data_o.tag_hit);
          if (out_data_o.slots_freed !== exp_r.slots_freed)
            $display("%0t:  slots_freed exp %0d act %0d", $time, exp_r.slots_freed,
                     out_data_o.slots_freed);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles with nothing accepted
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > WATCHDOG) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  task automatic test_directed();
    req_t r;
    // lookup and ack of empty slots, including the empty tag value
    send_item(rand_req(FN_LOOKUP, 16'hFFFF));
    send_item(rand_req(FN_ACK, 16'h0000));
    r = rand_req(FN_ADD, 16'hFFFF); r.packet_handle = '1; r.now_time = '1;
    send_item(r);
    send_item(rand_req(FN_LOOKUP, 16'hFFFF));
    r = rand_req(FN_ADD, 16'h0000); r.packet_handle = '0; r.now_time = '0;
    send_item(r);
    send_item(rand_req(FN_ADD, 16'h0100)); // overwrite unacked slot
    send_item(rand_req(FN_LOOKUP, 16'h0000)); // miss on tag
    send_item(rand_req(FN_SETRTX, 16'h0100));
    send_item(rand_req(FN_ACK, 16'h0100));
    send_item(rand_req(FN_ACK, 16'h0100));
    send_item(rand_req(FN_LOOKUP, 16'h0100));
    send_item(rand_req(FN_BAD6, 16'h0100));
    send_item(rand_req(FN_BAD7, 16'hFFFF));
    // wrap the resend count past 255
    repeat (257) send_item(rand_req(FN_RESENT, 16'hFFFF));
    send_item(rand_req(FN_LOOKUP, 16'hFFFF));
    // free: equal ends, wrap around zero, full space
    r = rand_req(FN_FREE, 16'h0005); r.range_end = 16'h0005; send_item(r);
    r = rand_req(FN_FREE, 16'hFFF0); r.range_end = 16'h0010; send_item(r);
    r = rand_req(FN_FREE, 16'h0001); r.range_end = 16'h0000; send_item(r);
    send_item(rand_req(FN_LOOKUP, 16'h0100));
    stop_sending();
  endtask

  task automatic test_random(int n);
    req_t r;
    int   pick;
    for (int k = 0; k < n; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 25) begin
        r = rand_req(FN_ADD, next_sn);
        next_sn = next_sn + 16'($urandom_range(1, 3));
      end else if (pick < 90) begin
        // mostly recent sequence numbers so tags hit
        r = rand_req(func_e'($urandom_range(1, 5)), 16'(next_sn - $urandom_range(1, 300)));
        if (r.func == FN_FREE) r.range_end = 16'(r.seq_num + $urandom_range(0, 20));
      end else begin
        r = rand_req(3'($urandom_range(0, 7)), 16'($urandom));
        if (r.func == FN_FREE && $urandom_range(0, 3) != 0)
          r.range_end = 16'(r.seq_num + $urandom_range(0, 40));
      end
      send_item(r);
    end
    stop_sending();
  endtask

  task automatic test_backpressure();
    rx_hold = 1'b1;
    fork
      begin
        repeat (300) @(negedge clk_i);
        rx_hold = 1'b0;
      end
      test_random(20);
    join
    drain_results();
  endtask

  task automatic test_no_idle();
    idle_pct = 0;
    test_random(300);
    idle_pct = 22;
  endtask

  initial begin
    for (int i = 0; i < DEPTH; i++) clear_slot(i);
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    test_directed();
    drain_results();
    test_random(500);
    test_backpressure();
    test_no_idle();
    test_random(250);
    drain_results();
    if (errors == 0) $display("PASSED: all results match");
    else $display("FAILED: results differ");
    $finish;
  end

endmodule
